/* hw/rtl/dpd_pkg.sv */
`default_nettype none

package dpd_pkg;

    localparam logic [7:0] CH_ACK = 8'h2B;
    localparam logic [7:0] CH_NAK = 8'h2D;
    localparam logic [7:0] CH_SOP = 8'h24;
    localparam logic [7:0] CH_EOP = 8'h23;

    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int COUNT_W = 10;
    localparam int LEN_W   = 9;
    localparam int LIMIT_W = 13;

    typedef enum logic [1:0] {
        FUNC_BYTE     = 2'd0,
        FUNC_TX_DONE  = 2'd1,
        FUNC_LINK_RST = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_BODY   = 3'd1,
        EV_GOOD   = 3'd2,
        EV_BAD    = 3'd3,
        EV_ACK    = 3'd4,
        EV_RESEND = 3'd5,
        EV_DROP   = 3'd6
    } event_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] rx_byte;
        logic       is_ack;
        logic       is_nak;
        logic       is_sop;
        logic       is_eop;
        logic [4:0] hex;
    } dpd_item_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dpd_front.sv */
`default_nettype none

module dpd_front import dpd_pkg::*; (
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_func,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output dpd_item_t       q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // classify the byte once so the back end only looks at flags
    always_comb begin
        q_item.func    = func_t'(s_func);
        q_item.rx_byte = s_rx_byte;
        q_item.is_ack  = (s_rx_byte == CH_ACK);
        q_item.is_nak  = (s_rx_byte == CH_NAK);
        q_item.is_sop  = (s_rx_byte == CH_SOP);
        q_item.is_eop  = (s_rx_byte == CH_EOP);
        q_item.hex     = hex_value(s_rx_byte);
    end

endmodule

`default_nettype wire

/* hw/rtl/dpd_fifo.sv */
`default_nettype none

module dpd_fifo import dpd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire dpd_item_t   push_item,
    input  wire logic        pop,
    output dpd_item_t        pop_item,
    output logic             empty,
    output logic             full,
    output logic [QCNT_W-1:0] level
);

    dpd_item_t             mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     level_reg, level_next;

    assign empty    = (level_reg == '0);
    assign full     = (level_reg == QCNT_W'(QDEPTH));
    assign level    = level_reg;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dpd_back.sv */
`default_nettype none

module dpd_back import dpd_pkg::*; #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dpd_item_t        q_item,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_event_res,
    output logic [7:0]            m_data_byte,
    output logic [LEN_W-1:0]      m_body_length,
    output logic [7:0]            m_command_char
);

    localparam logic [LIMIT_W-1:0] BODY_LIMIT = LIMIT_W'(BUFFER_BYTES - 4);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_BODY = 2'd1,
        PH_DIG1 = 2'd2,
        PH_DIG2 = 2'd3
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [7:0]           sum_reg, sum_next;
    logic [4:0]           hd_reg, hd_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [7:0]           first_reg, first_next;
    logic                 pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    event_t               m_event_reg, m_event_next;
    logic [7:0]           m_data_reg, m_data_next;
    logic [LEN_W-1:0]     m_len_reg, m_len_next;
    logic [7:0]           m_cmd_reg, m_cmd_next;

    logic [COUNT_W:0]     count_inc;
    logic                 overlong;
    logic                 sum_match;

    assign q_pop          = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid        = m_valid_reg;
    assign m_event_res    = m_event_reg;
    assign m_data_byte    = m_data_reg;
    assign m_body_length  = m_len_reg;
    assign m_command_char = m_cmd_reg;

    assign count_inc = {1'b0, count_reg} + 1'b1;
    assign overlong  = LIMIT_W'(count_inc) > BODY_LIMIT;
    assign sum_match = (hd_reg != HEX_NONE) && (q_item.hex != HEX_NONE)
                       && ({hd_reg[3:0], q_item.hex[3:0]} == sum_reg);

    always_comb begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        hd_next      = hd_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        pend_next    = pend_reg;
        m_event_next = m_event_reg;
        m_data_next  = m_data_reg;
        m_len_next   = m_len_reg;
        m_cmd_next   = m_cmd_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        if (q_pop) begin
            m_valid_next = 1'b1;
            m_event_next = EV_NONE;
            m_data_next  = '0;
            m_len_next   = '0;
            m_cmd_next   = '0;

            case (q_item.func)
                FUNC_TX_DONE: begin
                    pend_next = 1'b1;
                end
                FUNC_LINK_RST: begin
                    phase_next = PH_IDLE;
                    sum_next   = '0;
                    hd_next    = '0;
                    count_next = '0;
                    first_next = '0;
                    pend_next  = 1'b0;
                end
                FUNC_BYTE: begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (q_item.is_ack) begin
                                pend_next    = 1'b0;
                                m_event_next = EV_ACK;
                            end else if (q_item.is_nak) begin
                                if (pend_reg) begin
                                    m_event_next = EV_RESEND;
                                end else begin
                                    m_event_next = EV_DROP;
                                    sum_next     = '0;
                                    hd_next      = '0;
                                    count_next   = '0;
                                    first_next   = '0;
                                end
                            end else if (q_item.is_sop) begin
                                phase_next = PH_BODY;
                                sum_next   = '0;
                                hd_next    = '0;
                                count_next = '0;
                                first_next = '0;
                            end
                        end
                        PH_BODY: begin
                            if (q_item.is_eop) begin
                                phase_next = PH_DIG1;
                            end else if (overlong) begin
                                // drop the link and the whole frame with it
                                m_event_next = EV_DROP;
                                phase_next   = PH_IDLE;
                                sum_next     = '0;
                                hd_next      = '0;
                                count_next   = '0;
                                first_next   = '0;
                                pend_next    = 1'b0;
                            end else begin
                                if (count_reg == '0) begin
                                    first_next = q_item.rx_byte;
                                end
                                sum_next     = sum_reg + q_item.rx_byte;
                                count_next   = count_inc[COUNT_W-1:0];
                                m_event_next = EV_BODY;
                                m_data_next  = q_item.rx_byte;
                            end
                        end
                        PH_DIG1: begin
                            hd_next    = q_item.hex;
                            phase_next = PH_DIG2;
                        end
                        default: begin
                            if (sum_match) begin
                                m_event_next = EV_GOOD;
                                m_len_next   = count_reg[LEN_W-1:0];
                                m_cmd_next   = (count_reg != '0) ? first_reg : 8'h00;
                            end else begin
                                m_event_next = EV_BAD;
                            end
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            sum_reg     <= '0;
            hd_reg      <= '0;
            count_reg   <= '0;
            first_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            hd_reg      <= hd_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        m_event_reg <= m_event_next;
        m_data_reg  <= m_data_next;
        m_len_reg   <= m_len_next;
        m_cmd_reg   <= m_cmd_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/debug_packet_deframer_top.sv */
// Deframer for a debug serial link: frames are '$', body, '#', two hex digits.
// Input channel (s_): s_func selects received byte, reply transmitted or link
// reset; s_rx_byte carries the byte. Every input transaction gives exactly one
// result transaction on the m_ channel: an event code with the body byte, the
// body length and the command character where the event carries them.
// The queue holds each accepted input; the queue head feeds the back end, which
// loads the output register when it pops the entry.
// Throughput: one transaction per cycle while no result is held or the receiver
// takes the held one; the per-byte state update in the back end is registered.
// A four-entry queue separates the classifier from the back end, so input is
// still taken while the receiver stalls until the queue fills; s_ready then
// drops until the receiver takes the held result.
// Reset (aresetn low, synchronous) empties the queue, drops any held result and
// returns the framer to idle with no reply pending.
`default_nettype none

module debug_packet_deframer_top import dpd_pkg::*; #(
    parameter int BUFFER_BYTES = 512
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_func,
    input  wire logic [7:0]       s_rx_byte,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_event_res,
    output logic [7:0]            m_data_byte,
    output logic [LEN_W-1:0]      m_body_length,
    output logic [7:0]            m_command_char
);

    dpd_item_t         push_item;
    dpd_item_t         pop_item;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;
    logic [QCNT_W-1:0] q_level;

    dpd_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    dpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .full      (q_full),
        .level     (q_level)
    );

    dpd_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_item         (pop_item),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_data_byte    (m_data_byte),
        .m_body_length  (m_body_length),
        .m_command_char (m_command_char)
    );

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= QCNT_W'(QDEPTH))
        else $error("queue level beyond depth");

    a_ready_tracks_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (q_level != QCNT_W'(QDEPTH)))
        else $error("input ready out of step with queue level");

    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!q_empty && (!m_valid || m_ready)))
        else $error("queue popped with no room for the result");

    a_empty_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_GOOD && m_body_length == '0)
        |-> m_command_char == 8'h00)
        else $error("empty good packet carries a command character");

    a_data_only_body: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res != EV_BODY) |-> m_data_byte == 8'h00)
        else $error("data byte set on a non-body event");

endmodule

`default_nettype wire
